FILE: rtl/hmsc_pkg.sv
// Shared types and constants for the hms clock with drift correction and chime.
// Depends on nothing; used by hms_clock_with_drift_and_chime.
package hmsc_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_DIV,
        SEQ_DONE
    } seq_state_t;

    // Input item kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_MODE  = 3'd1;
    localparam logic [2:0] KIND_UP    = 3'd2;
    localparam logic [2:0] KIND_DOWN  = 3'd3;
    localparam logic [2:0] KIND_ALARM = 3'd4;
    localparam logic [2:0] KIND_SER   = 3'd5;

    // Set modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_HOUR   = 2'd1;
    localparam logic [1:0] MODE_MINUTE = 2'd2;

    // Serial read commands
    localparam logic [7:0] CMD_HOUR   = 8'd0;
    localparam logic [7:0] CMD_MINUTE = 8'd1;
    localparam logic [7:0] CMD_SECOND = 8'd2;
    localparam logic [7:0] CMD_BEAT_A = 8'd3;
    localparam logic [7:0] CMD_BEAT_B = 8'd4;
    localparam logic [7:0] CMD_MODE   = 8'd5;
    localparam logic [7:0] CMD_ALARM  = 8'd6;
    localparam logic [7:0] CMD_DRIFT  = 8'd7;
    // Serial set command bases
    localparam logic [7:0] CMD_SET_HOUR = 8'd8;
    localparam logic [7:0] CMD_SET_MIN  = 8'd32;
    localparam logic [7:0] CMD_SET_SEC  = 8'd92;
    // First rejected command byte
    localparam logic [7:0] CMD_NAK_BASE = 8'd152;

    localparam logic [7:0] ACK_BYTE = 8'h21;
    localparam logic [7:0] NAK_BYTE = 8'h3F;

    // Configuration register indexes
    localparam logic REG_TPS   = 1'b0;
    localparam logic REG_DRIFT = 1'b1;

    // Reset values
    localparam logic [4:0]  RST_TPS   = 5'd20;
    localparam logic [11:0] RST_DRIFT = 12'd2789;
    localparam logic [5:0]  RST_SEC   = 6'd57;
    localparam logic [5:0]  RST_MIN   = 6'd59;
    localparam logic [4:0]  RST_HOUR  = 5'd11;

    localparam int DIV_STEPS = 12;

endpackage

FILE: rtl/hms_clock_with_drift_and_chime.sv
// Top level of the 24-hour clock with drift correction, hourly chime and serial access.
// Depends on hmsc_pkg.
//
// Usage:
//   Input items enter on the s_ group: s_tuser carries the item kind (tick, mode key,
//   up key, down key, alarm key, serial byte) and s_tdata the serial command byte.
//   Each input item yields exactly one result item on the m_ group: the clock state
//   after the item, plus the serial reply for serial bytes (m_tuser flags it).
//   Registers ticks_per_second (address 0) and drift_period (address 4) are written
//   over the APB-style port while idle (a user rule, unenforced); pready is tied high.
// Sequencing:
//   An accepted item passes through the EXEC and DONE states, and its result is loaded
//   into the output register as the sequencer returns to idle; no new item is taken
//   before then. The drift-counter read command adds the DIV state, where a shared
//   restoring divider runs one quotient bit per cycle, 12 steps.
//   s_tready is high only while the sequencer is idle.
// Reset:
//   rst_n clears the clock to 11:59:57, normal mode, alarm off, chime level high,
//   and restores the register defaults. No result is pending after reset.
// Stall:
//   A finished result sits in the output register until m_tready; the next item is
//   still accepted and worked, and it waits only if its own result finds the output
//   register still full.
module hms_clock_with_drift_and_chime (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cmd_byte
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                   // [18:17] key_mode, [19] alarm_on, [20] half_beat,
                                   // [21] chime_level, [22] drift_pulse,
                                   // [30:23] reply_byte, [31] zero
    output logic [0:0]  m_tuser,   // [0] reply_valid
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hmsc_pkg::seq_state_t state_reg, state_next;

    // configuration
    logic [4:0]  tps_reg;
    logic [11:0] dp_reg;

    // clock state
    logic [4:0]  tick_reg,  tick_next;
    logic [5:0]  sec_reg,   sec_next;
    logic [5:0]  min_reg,   min_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [11:0] drift_reg, drift_next;
    logic [1:0]  mode_reg,  mode_next;
    logic        alarm_reg, alarm_next;
    logic        beat_reg,  beat_next;
    logic        chime_reg, chime_next;

    // item being worked
    logic [2:0]  kind_reg;
    logic [7:0]  cmd_reg;
    logic        pulse_reg, pulse_next;
    logic        rvalid_reg, rvalid_next;
    logic [7:0]  rbyte_reg, rbyte_next;

    // shared divider
    logic [4:0]  rem_reg,  rem_next;
    logic [11:0] quo_reg,  quo_next;
    logic [4:0]  dvs_reg,  dvs_next;
    logic [3:0]  cnt_reg,  cnt_next;

    // output register
    logic        mval_reg, mval_next;
    logic [31:0] mdata_reg;
    logic        muser_reg;
    logic        load_out;

    // combinational helpers
    logic [4:0]  tc_inc;
    logic [11:0] dc_inc;
    logic [5:0]  sec_adv;
    logic [5:0]  min_adv;
    logic [4:0]  hour_adv;
    logic [12:0] dp_sum;
    logic [4:0]  dp_q;
    logic [5:0]  trial;
    logic [5:0]  trial_diff;
    logic        trial_ge;

    logic cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == hmsc_pkg::REG_DRIFT) ? {20'd0, dp_reg} : {27'd0, tps_reg};
    assign s_tready = (state_reg == hmsc_pkg::SEQ_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // drift_period / 255 by reciprocal: (x + (x >> 8) + 1) >> 8, exact for 12-bit x
    assign dp_sum = {1'b0, dp_reg} + {5'd0, dp_reg[11:8]} + 13'd1;
    assign dp_q   = (dp_sum[12:8] == 5'd0) ? 5'd1 : dp_sum[12:8];

    // one restoring step of the shared divider
    assign trial      = {rem_reg, quo_reg[11]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign trial_ge   = (trial >= {1'b0, dvs_reg});

    assign tc_inc = tick_reg + 5'd1;
    assign dc_inc = drift_reg + 12'd1;

    assign load_out = (state_reg == hmsc_pkg::SEQ_DONE) && (!mval_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        drift_next  = drift_reg;
        mode_next   = mode_reg;
        alarm_next  = alarm_reg;
        beat_next   = beat_reg;
        chime_next  = chime_reg;
        pulse_next  = pulse_reg;
        rvalid_next = rvalid_reg;
        rbyte_next  = rbyte_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        sec_adv     = sec_reg;
        min_adv     = min_reg;
        hour_adv    = hour_reg;
        mval_next   = mval_reg;

        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        case (state_reg)
            hmsc_pkg::SEQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = hmsc_pkg::SEQ_EXEC;
                end
            end

            hmsc_pkg::SEQ_EXEC:
            begin
                pulse_next  = 1'b0;
                rvalid_next = 1'b0;
                rbyte_next  = 8'd0;
                state_next  = hmsc_pkg::SEQ_DONE;
                case (kind_reg)
                    hmsc_pkg::KIND_TICK:
                    begin
                        if (tc_inc >= tps_reg)
                        begin
                            tick_next = 5'd0;
                            sec_adv   = sec_reg + 6'd1;
                            if (dc_inc >= dp_reg)
                            begin
                                drift_next = 12'd0;
                                sec_adv    = sec_reg + 6'd2;
                                pulse_next = 1'b1;
                            end
                            else
                            begin
                                drift_next = dc_inc;
                            end
                            beat_next = ~beat_reg;
                            // carry seconds into minutes into hours
                            if (sec_adv >= 6'd60)
                            begin
                                sec_adv = sec_adv - 6'd60;
                                min_adv = min_reg + 6'd1;
                            end
                            if (min_adv >= 6'd60)
                            begin
                                min_adv  = min_adv - 6'd60;
                                hour_adv = hour_reg + 5'd1;
                            end
                            if (hour_adv >= 5'd24)
                            begin
                                hour_adv = hour_adv - 5'd24;
                            end
                            sec_next  = sec_adv;
                            min_next  = min_adv;
                            hour_next = hour_adv;
                            if (alarm_reg && (mode_reg == hmsc_pkg::MODE_NORMAL) &&
                                (min_adv == 6'd0) && (sec_adv <= 6'd1))
                            begin
                                chime_next = ~chime_reg;
                            end
                        end
                        else
                        begin
                            tick_next = tc_inc;
                        end
                    end

                    hmsc_pkg::KIND_MODE:
                    begin
                        if (mode_reg >= hmsc_pkg::MODE_MINUTE)
                        begin
                            mode_next  = hmsc_pkg::MODE_NORMAL;
                            sec_next   = 6'd0;
                            tick_next  = 5'd0;
                            drift_next = 12'd0;
                        end
                        else
                        begin
                            mode_next = mode_reg + 2'd1;
                        end
                    end

                    hmsc_pkg::KIND_UP:
                    begin
                        if (mode_reg == hmsc_pkg::MODE_HOUR)
                        begin
                            hour_next = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
                        end
                        else if (mode_reg == hmsc_pkg::MODE_MINUTE)
                        begin
                            min_next = (min_reg >= 6'd59) ? 6'd0 : min_reg + 6'd1;
                        end
                    end

                    hmsc_pkg::KIND_DOWN:
                    begin
                        if (mode_reg == hmsc_pkg::MODE_HOUR)
                        begin
                            hour_next = (hour_reg == 5'd0 || hour_reg > 5'd23) ?
                                        5'd23 : hour_reg - 5'd1;
                        end
                        else if (mode_reg == hmsc_pkg::MODE_MINUTE)
                        begin
                            min_next = (min_reg == 6'd0 || min_reg > 6'd59) ?
                                       6'd59 : min_reg - 6'd1;
                        end
                    end

                    hmsc_pkg::KIND_ALARM:
                    begin
                        if (mode_reg != hmsc_pkg::MODE_NORMAL)
                        begin
                            mode_next = hmsc_pkg::MODE_NORMAL;
                        end
                        else if (!((min_reg == 6'd0) && (sec_reg <= 6'd1)))
                        begin
                            alarm_next = ~alarm_reg;
                        end
                    end

                    hmsc_pkg::KIND_SER:
                    begin
                        rvalid_next = 1'b1;
                        case (cmd_reg) inside
                            hmsc_pkg::CMD_HOUR:   rbyte_next = {3'd0, hour_reg};
                            hmsc_pkg::CMD_MINUTE: rbyte_next = {2'd0, min_reg};
                            hmsc_pkg::CMD_SECOND: rbyte_next = {2'd0, sec_reg};
                            hmsc_pkg::CMD_BEAT_A,
                            hmsc_pkg::CMD_BEAT_B: rbyte_next = {7'd0, beat_reg};
                            hmsc_pkg::CMD_MODE:   rbyte_next = {6'd0, mode_reg};
                            hmsc_pkg::CMD_ALARM:  rbyte_next = {7'd0, alarm_reg};
                            hmsc_pkg::CMD_DRIFT:
                            begin
                                // start the divider: drift_count / divisor
                                rem_next   = 5'd0;
                                quo_next   = drift_reg;
                                dvs_next   = dp_q;
                                cnt_next   = 4'(hmsc_pkg::DIV_STEPS - 1);
                                state_next = hmsc_pkg::SEQ_DIV;
                            end
                            [hmsc_pkg::CMD_SET_HOUR:hmsc_pkg::CMD_SET_MIN - 8'd1]:
                            begin
                                hour_next  = 5'(cmd_reg - hmsc_pkg::CMD_SET_HOUR);
                                rbyte_next = hmsc_pkg::ACK_BYTE;
                            end
                            [hmsc_pkg::CMD_SET_MIN:hmsc_pkg::CMD_SET_SEC - 8'd1]:
                            begin
                                min_next   = 6'(cmd_reg - hmsc_pkg::CMD_SET_MIN);
                                rbyte_next = hmsc_pkg::ACK_BYTE;
                            end
                            [hmsc_pkg::CMD_SET_SEC:hmsc_pkg::CMD_NAK_BASE - 8'd1]:
                            begin
                                sec_next   = 6'(cmd_reg - hmsc_pkg::CMD_SET_SEC);
                                drift_next = 12'd0;
                                tick_next  = 5'd0;
                                rbyte_next = hmsc_pkg::ACK_BYTE;
                            end
                            default:
                            begin
                                rbyte_next = hmsc_pkg::NAK_BYTE;
                            end
                        endcase
                    end

                    default:
                    begin
                        // unknown kind: report state, no reply
                    end
                endcase
            end

            hmsc_pkg::SEQ_DIV:
            begin
                rem_next = trial_ge ? trial_diff[4:0] : trial[4:0];
                quo_next = {quo_reg[10:0], trial_ge};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    rbyte_next = {quo_reg[6:0], trial_ge};
                    state_next = hmsc_pkg::SEQ_DONE;
                end
            end

            hmsc_pkg::SEQ_DONE:
            begin
                if (load_out)
                begin
                    mval_next  = 1'b1;
                    state_next = hmsc_pkg::SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = hmsc_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmsc_pkg::SEQ_IDLE;
            tps_reg   <= hmsc_pkg::RST_TPS;
            dp_reg    <= hmsc_pkg::RST_DRIFT;
            tick_reg  <= 5'd0;
            sec_reg   <= hmsc_pkg::RST_SEC;
            min_reg   <= hmsc_pkg::RST_MIN;
            hour_reg  <= hmsc_pkg::RST_HOUR;
            drift_reg <= 12'd0;
            mode_reg  <= hmsc_pkg::MODE_NORMAL;
            alarm_reg <= 1'b0;
            beat_reg  <= 1'b0;
            chime_reg <= 1'b1;
            cnt_reg   <= 4'd0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            drift_reg <= drift_next;
            mode_reg  <= mode_next;
            alarm_reg <= alarm_next;
            beat_reg  <= beat_next;
            chime_reg <= chime_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
            if (cfg_wr && paddr[2] == hmsc_pkg::REG_TPS)
            begin
                tps_reg <= pwdata[4:0];
            end
            if (cfg_wr && paddr[2] == hmsc_pkg::REG_DRIFT)
            begin
                dp_reg <= pwdata[11:0];
            end
        end
    end

    // payload: item, divider and output register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            cmd_reg  <= s_tdata;
        end
        pulse_reg  <= pulse_next;
        rvalid_reg <= rvalid_next;
        rbyte_reg  <= rbyte_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        if (load_out)
        begin
            mdata_reg <= {1'b0, rbyte_reg, pulse_reg, chime_reg, beat_reg, alarm_reg,
                          mode_reg, sec_reg, min_reg, hour_reg};
            muser_reg <= rvalid_reg;
        end
    end

    // an accepted item closes the input until its result is loaded into the output register
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    // shown time stays in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] < 5'd24 && m_tdata[10:5] < 6'd60 &&
                      m_tdata[16:11] < 6'd60))
        else $error("time field out of range");

    // no reply byte without a reply
    a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[30:23] == 8'd0))
        else $error("reply byte set without reply");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hmsc_pkg::SEQ_DIV) |-> (dvs_reg != 5'd0))
        else $error("divider running with zero divisor");

    // a result waiting on a stalled receiver is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule
